FILE: rtl/htfi_pkg.sv
// Shared constants, codes and controller/datapath structs for the hash table.
package htfi_pkg;

    // Table geometry
    localparam int TABLE_SIZE  = 4096;
    localparam int SLOT_W      = $clog2(TABLE_SIZE);
    localparam int IDX_W       = 12;
    localparam int ACT_W       = 2;
    localparam int WORD_W      = 64;

    // Hash constants
    localparam logic [WORD_W-1:0] HASH_SEED  = 64'd14695981039346656037;
    localparam logic [8:0]        PRIME_LOW  = 9'h1B3;
    localparam int                PRIME_SHIFT = 40;
    localparam int                PROBE_SCALE = 6659;
    localparam int                M_W  = $clog2(TABLE_SIZE * PROBE_SCALE + 1);
    localparam int                MUL_W = 32 + M_W;
    localparam int                STEP_W = 4;
    localparam int                LAST_STEP = 8;

    // Actions
    localparam logic [ACT_W-1:0] ACT_FIND = 2'd0;
    localparam logic [ACT_W-1:0] ACT_GET  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SET  = 2'd2;

    // Hash datapath operations
    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_LOADK  = 3'd1;
    localparam logic [2:0] OP_MLO    = 3'd2;
    localparam logic [2:0] OP_MHI    = 3'd3;
    localparam logic [2:0] OP_MPRIME = 3'd4;

    // Post-processing after an operation
    localparam logic [2:0] PST_NONE  = 3'd0;
    localparam logic [2:0] PST_XSEED = 3'd1;
    localparam logic [2:0] PST_ROT47 = 3'd2;
    localparam logic [2:0] PST_XKROT = 3'd3;
    localparam logic [2:0] PST_FOLD  = 3'd4;

    // Result kinds
    localparam logic [2:0] RES_NONE  = 3'd0;
    localparam logic [2:0] RES_PROBE = 3'd1;
    localparam logic [2:0] RES_FULL  = 3'd2;
    localparam logic [2:0] RES_GET   = 3'd3;
    localparam logic [2:0] RES_ADDR  = 3'd4;

    typedef struct packed {
        logic       load_in;
        logic [2:0] op;
        logic [2:0] post;
        logic       probe_start;
        logic       probe_next;
        logic       rd_probe;
        logic       rd_addr;
        logic       wr_probe;
        logic       wr_addr;
        logic       clr_step;
        logic       res_load;
        logic [2:0] res_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic             clr_done;
        logic             entry_empty;
        logic             entry_match;
        logic             last_probe;
        logic             out_busy;
        logic [ACT_W-1:0] action;
    } dp_sts_t;

endpackage

FILE: rtl/htfi_req_if.sv
// Request channel: action, key words and slot index.
interface htfi_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [11:0] slot_index;

    modport source (output valid, action, key_high, key_low, slot_index, input ready);
    modport sink   (input valid, action, key_high, key_low, slot_index, output ready);
endinterface

FILE: rtl/htfi_rsp_if.sv
// Response channel: slot, entry data and status.
interface htfi_rsp_if;
    logic        valid;
    logic        ready;
    logic [11:0] slot;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic        status;

    modport source (output valid, slot, data_high, data_low, status, input ready);
    modport sink   (input valid, slot, data_high, data_low, status, output ready);
endinterface

FILE: rtl/htfi_dp.sv
// Datapath: input registers, hash unit, entry memory and result register.
module htfi_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  htfi_pkg::dp_cmd_t    cmd,
    output htfi_pkg::dp_sts_t    sts,
    htfi_req_if.sink             req,
    htfi_rsp_if.source           rsp
);
    import htfi_pkg::*;

    logic [ACT_W-1:0]    act_reg;
    logic [WORD_W-1:0]   kh_reg;
    logic [WORD_W-1:0]   kl_reg;
    logic [SLOT_W-1:0]   idx_reg;
    logic [WORD_W-1:0]   h_reg;
    logic [WORD_W-1:0]   h_next;
    logic [MUL_W-1:0]    acc_reg;
    logic [M_W-1:0]      m_reg;
    logic [SLOT_W-1:0]   k_reg;
    logic [SLOT_W-1:0]   clr_cnt_reg;
    logic [2*WORD_W-1:0] mem [TABLE_SIZE];
    logic [2*WORD_W-1:0] rdata_reg;
    logic [MUL_W-1:0]    prod_lo;
    logic [MUL_W-1:0]    prod_hi;
    logic [WORD_W+8:0]   prod_pr;
    logic [WORD_W-1:0]   op_val;
    logic [WORD_W-1:0]   xk;
    logic [SLOT_W-1:0]   probe_slot;
    logic                out_valid_reg;
    logic [IDX_W-1:0]    slot_out_reg;
    logic [WORD_W-1:0]   dh_reg;
    logic [WORD_W-1:0]   dl_reg;
    logic                status_reg;

    // Latch the accepted request
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            act_reg <= req.action;
            kh_reg  <= req.key_high;
            kl_reg  <= req.key_low;
            idx_reg <= req.slot_index[SLOT_W-1:0];
        end
    end

    // Multiply products, one partial product per cycle
    assign prod_lo = MUL_W'(h_reg[31:0]) * MUL_W'(m_reg);
    assign prod_hi = MUL_W'(h_reg[63:32]) * MUL_W'(m_reg);
    assign prod_pr = (WORD_W+9)'(h_reg) * (WORD_W+9)'(PRIME_LOW);

    // Select the operation result
    always_comb
    begin
        case (cmd.op)
            OP_LOADK:  op_val = kh_reg;
            OP_MHI:    op_val = {{(WORD_W-MUL_W){1'b0}}, acc_reg} + {prod_hi[31:0], 32'b0};
            OP_MPRIME: op_val = prod_pr[WORD_W-1:0] + (h_reg << PRIME_SHIFT);
            default:   op_val = h_reg;
        endcase
    end

    // Apply the post step
    assign xk = op_val ^ kl_reg;
    always_comb
    begin
        case (cmd.post)
            PST_XSEED: h_next = op_val ^ HASH_SEED;
            PST_ROT47: h_next = {op_val[16:0], op_val[63:17]};
            PST_XKROT: h_next = {xk[32:0], xk[63:33]};
            PST_FOLD:  h_next = op_val ^ (op_val >> 32);
            default:   h_next = op_val;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_MLO)
        begin
            acc_reg <= prod_lo;
        end
        if (cmd.op != OP_NONE && cmd.op != OP_MLO)
        begin
            h_reg <= h_next;
        end
    end

    // Probe counter and scale
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg       <= '0;
            m_reg       <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.probe_start)
            begin
                k_reg <= '0;
                m_reg <= M_W'(PROBE_SCALE);
            end
            else if (cmd.probe_next)
            begin
                k_reg <= k_reg + 1'b1;
                m_reg <= m_reg + M_W'(PROBE_SCALE);
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    assign probe_slot = h_reg[SLOT_W-1:0];

    // Entry memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.wr_probe)
        begin
            mem[probe_slot] <= {kh_reg, kl_reg};
        end
        else if (cmd.wr_addr)
        begin
            mem[idx_reg] <= {kh_reg, kl_reg};
        end
        if (cmd.rd_probe)
        begin
            rdata_reg <= mem[probe_slot];
        end
        else if (cmd.rd_addr)
        begin
            rdata_reg <= mem[idx_reg];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            slot_out_reg <= '0;
            dh_reg       <= '0;
            dl_reg       <= '0;
            status_reg   <= 1'b0;
            case (cmd.res_sel)
                RES_PROBE: slot_out_reg <= IDX_W'(probe_slot);
                RES_FULL:  status_reg   <= 1'b1;
                RES_GET:
                begin
                    slot_out_reg <= IDX_W'(idx_reg);
                    dh_reg       <= rdata_reg[2*WORD_W-1:WORD_W];
                    dl_reg       <= rdata_reg[WORD_W-1:0];
                end
                RES_ADDR:  slot_out_reg <= IDX_W'(idx_reg);
                default:   slot_out_reg <= '0;
            endcase
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.slot      = slot_out_reg;
    assign rsp.data_high = dh_reg;
    assign rsp.data_low  = dl_reg;
    assign rsp.status    = status_reg;

    assign sts.clr_done    = (clr_cnt_reg == SLOT_W'(TABLE_SIZE - 1));
    assign sts.entry_empty = (rdata_reg == '0);
    assign sts.entry_match = (rdata_reg == {kh_reg, kl_reg});
    assign sts.last_probe  = (k_reg == SLOT_W'(TABLE_SIZE - 1));
    assign sts.out_busy    = out_valid_reg;
    assign sts.action      = act_reg;
endmodule

FILE: rtl/htfi_ctrl.sv
// Controller: clearing pass, action dispatch, hash step sequencing and probing.
module htfi_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  htfi_pkg::dp_sts_t    sts,
    output htfi_pkg::dp_cmd_t    cmd
);
    import htfi_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DISP  = 3'd2;
    localparam logic [2:0] ST_HASH  = 3'd3;
    localparam logic [2:0] ST_PRD   = 3'd4;
    localparam logic [2:0] ST_PCMP  = 3'd5;
    localparam logic [2:0] ST_RRD   = 3'd6;
    localparam logic [2:0] ST_RRET  = 3'd7;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    assign req_ready = (state_reg == ST_IDLE) && !sts.out_busy;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DISP;
                end
            end
            ST_DISP:
            begin
                case (sts.action)
                    ACT_FIND:
                    begin
                        cmd.probe_start = 1'b1;
                        step_next       = '0;
                        state_next      = ST_HASH;
                    end
                    ACT_GET:
                    begin
                        state_next = ST_RRD;
                    end
                    ACT_SET:
                    begin
                        cmd.wr_addr  = 1'b1;
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = RES_ADDR;
                        state_next   = ST_IDLE;
                    end
                    default:
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = RES_NONE;
                        state_next   = ST_IDLE;
                    end
                endcase
            end
            ST_HASH:
            begin
                case (step_reg)
                    4'd0:    cmd.op = OP_LOADK;
                    4'd1:    cmd.op = OP_MLO;
                    4'd2:
                    begin
                        cmd.op   = OP_MHI;
                        cmd.post = PST_XSEED;
                    end
                    4'd3:    cmd.op = OP_MLO;
                    4'd4:
                    begin
                        cmd.op   = OP_MHI;
                        cmd.post = PST_ROT47;
                    end
                    4'd5:    cmd.op = OP_MPRIME;
                    4'd6:    cmd.op = OP_MLO;
                    4'd7:
                    begin
                        cmd.op   = OP_MHI;
                        cmd.post = PST_XKROT;
                    end
                    4'd8:
                    begin
                        cmd.op   = OP_MPRIME;
                        cmd.post = PST_FOLD;
                    end
                    default: cmd.op = OP_NONE;
                endcase
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(LAST_STEP))
                begin
                    state_next = ST_PRD;
                end
            end
            ST_PRD:
            begin
                cmd.rd_probe = 1'b1;
                state_next   = ST_PCMP;
            end
            ST_PCMP:
            begin
                state_next = ST_IDLE;
                if (sts.entry_empty)
                begin
                    cmd.wr_probe = 1'b1;
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_PROBE;
                end
                else if (sts.entry_match)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_PROBE;
                end
                else if (sts.last_probe)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_FULL;
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                    step_next      = '0;
                    state_next     = ST_HASH;
                end
            end
            ST_RRD:
            begin
                cmd.rd_addr = 1'b1;
                state_next  = ST_RRET;
            end
            ST_RRET:
            begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_GET;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end
endmodule

FILE: rtl/hash_table_find_or_insert.sv
// Hash table of 4096 entries of 128 bits with find-or-insert, retrieve and set. After reset
// the block zeroes the table in a clearing pass and takes no request until it ends. A request
// is then handled one at a time: set and an unused action go from dispatch straight to the
// result, retrieve through a registered table read, and find-or-insert, per probe, through the
// hash steps in the shared hash unit (one 32-bit partial product of a 64-bit multiply per cycle)
// and then the registered table read and compare. A new request is taken once the result has been transferred.
module hash_table_find_or_insert (
    input  logic       clk,
    input  logic       rst_n,
    htfi_req_if.sink   req,
    htfi_rsp_if.source rsp
);
    import htfi_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    ready;

    assign req.ready = ready;

    htfi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    htfi_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts),
        .req   (req),
        .rsp   (rsp)
    );

`ifndef NO_ASSERTIONS
    // One request at a time: never ready while a result waits
    assert property (@(posedge clk) disable iff (!rst_n) req.ready |-> !rsp.valid)
        else $error("request taken while a result is pending");
    // A full table reports slot zero and no data
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status |-> rsp.slot == 12'd0 && rsp.data_high == 64'd0
        && rsp.data_low == 64'd0)
        else $error("full status with nonzero fields");
    // A transfer in is followed by no result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) req.valid && req.ready |=> !rsp.valid)
        else $error("result appeared too early");
`endif
endmodule
